/* sv/tdpt_pkg.sv */
`default_nettype none

package tdpt_pkg;

  // default width of the tested value
  localparam int unsigned DefaultValueWidth = 31;

  // first odd trial divisor; two is covered by the parity check
  localparam int unsigned FirstOddDivisor = 3;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StSqTest,
    StDiv,
    StFinish
  } tdpt_state_e;

  // status from the remainder unit to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } tdpt_rem_status_t;

endpackage

`default_nettype wire

/* sv/tdpt_if.sv */
`default_nettype none

// value channel
interface tdpt_value_if #(
  parameter int unsigned VALUE_WIDTH = 31
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// result channel
interface tdpt_result_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

/* sv/tdpt_rem_unit.sv */
`default_nettype none

// restoring remainder unit: one quotient bit per cycle
module tdpt_rem_unit
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [VALUE_WIDTH-1:0] divisor_i,
  output      tdpt_rem_status_t       status_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] num_q, num_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, num_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_WIDTH);
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the value width
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[VALUE_WIDTH-1:0];
      end else begin
        rem_d = trial[VALUE_WIDTH-1:0];
      end
      num_d = num_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign status_o.busy     = busy_q;
  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

/* sv/trial_division_prime_test_top.sv */
// Trial-division prime test.
//
// value_i carries one unsigned value per transfer; result_o carries one
// is_prime bit per accepted value, in order. Both use valid/ready, and a
// transfer happens on a rising edge with valid and ready high.
// value_i.ready is high only while the sequencer is idle, so one value is
// worked on at a time. The result sits in an output register, so a new
// value may be taken while the previous result still waits.
// Zero, one and even values are settled without a trial. Odd values are
// divided by 3, 5, 7, 9, ... while the divisor squared does not exceed the
// value; each trial runs in the one shared bit-serial remainder unit, and
// a small factor ends the search early.
// If result_o.ready is low, a finished result waits in the sequencer until
// the output register is free; nothing is dropped.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and
// empties the output register; no other state is kept between values.
`default_nettype none

module trial_division_prime_test_top
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tdpt_value_if.sink   value_i,
  tdpt_result_if.source result_o
);

  localparam int unsigned SqW = VALUE_WIDTH + 2;

  tdpt_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic [SqW-1:0]         sq_q, sq_d;
  logic                   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_prime_q, out_prime_d;
  logic                   rem_start;
  tdpt_rem_status_t       rem_st;

  // shared remainder unit
  tdpt_rem_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .status_o  (rem_st)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    res_d       = res_q;
    rem_start   = 1'b0;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (value_i.valid) begin
          n_d     = value_i.value;
          state_d = StStart;
        end
      end
      StStart: begin
        // zero, one and even values settle at once
        if (n_q < VALUE_WIDTH'(2)) begin
          res_d   = 1'b0;
          state_d = StFinish;
        end else if (!n_q[0]) begin
          res_d   = (n_q == VALUE_WIDTH'(2));
          state_d = StFinish;
        end else begin
          d_d     = VALUE_WIDTH'(FirstOddDivisor);
          sq_d    = SqW'(FirstOddDivisor * FirstOddDivisor);
          state_d = StSqTest;
        end
      end
      StSqTest: begin
        // no divisor up to the square root: prime
        if (sq_q > {2'b00, n_q}) begin
          res_d   = 1'b1;
          state_d = StFinish;
        end else begin
          rem_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (rem_st.done) begin
          if (rem_st.rem_zero) begin
            res_d   = 1'b0;
            state_d = StFinish;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_d     = d_q + VALUE_WIDTH'(2);
            sq_d    = sq_q + {d_q, 2'b00} + SqW'(4);
            state_d = StSqTest;
          end
        end
      end
      StFinish: begin
        // wait for a free output register
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_prime_d = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    res_q       <= res_d;
    out_prime_q <= out_prime_d;
  end

  assign value_i.ready     = (state_q == StIdle);
  assign result_o.valid    = out_valid_q;
  assign result_o.is_prime = out_prime_q;

  // remainder unit is idle whenever a new value can be taken
  a_rem_idle_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_i.ready |-> !rem_st.busy && !rem_st.done)
    else $error("remainder unit active while sequencer idle");

  // a remainder completes only while the sequencer waits for it
  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_st.done |-> state_q == StDiv)
    else $error("remainder completed outside the divide state");

  // odd divisors give odd squares
  a_odd_square : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSqTest |-> d_q[0] && sq_q[0])
    else $error("trial divisor or its square lost oddness");

  // a finished result is held back while the output register is stalled
  a_finish_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFinish && out_valid_q && !result_o.ready |=> state_q == StFinish)
    else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire
